// ===== rtl/rwsc_pkg.sv =====
`default_nettype none

package rwsc_pkg;

  localparam int unsigned PlanSlotsDefault = 10;

  localparam int unsigned OpcodeW = 3;
  localparam int unsigned DayW    = 3;
  localparam int unsigned SecW    = 17;
  localparam int unsigned DaysW   = 7;
  localparam int unsigned LoopW   = 24;
  localparam int unsigned UsedW   = 4;
  localparam int unsigned ErrW    = 2;

  localparam logic [OpcodeW-1:0] OP_TICK   = 3'd0;
  localparam logic [OpcodeW-1:0] OP_BUTTON = 3'd1;
  localparam logic [OpcodeW-1:0] OP_OFF    = 3'd2;
  localparam logic [OpcodeW-1:0] OP_ON     = 3'd3;
  localparam logic [OpcodeW-1:0] OP_TOGGLE = 3'd4;
  localparam logic [OpcodeW-1:0] OP_LOOP   = 3'd5;
  localparam logic [OpcodeW-1:0] OP_PLAN   = 3'd6;

  localparam logic [ErrW-1:0] ERR_NONE = 2'd0;
  localparam logic [ErrW-1:0] ERR_FULL = 2'd1;
  localparam logic [ErrW-1:0] ERR_LOOP = 2'd2;

  localparam logic [DayW-1:0] DAY_SUNDAY   = 3'd0;
  localparam logic [DayW-1:0] DAY_SATURDAY = 3'd6;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } rwsc_state_e;

  typedef struct packed {
    logic [DaysW-1:0] days;
    logic [SecW-1:0]  on_sec;
    logic [SecW-1:0]  off_sec;
    logic             in_window;
  } plan_entry_t;

endpackage

`default_nettype wire

// ===== rtl/rwsc_if.sv =====
`default_nettype none

interface rwsc_in_if;
  import rwsc_pkg::*;

  logic               valid;
  logic               ready;
  logic [OpcodeW-1:0] opcode;
  logic [DayW-1:0]    day_of_week;
  logic [SecW-1:0]    second_of_day;
  logic [DaysW-1:0]   weekday_set;
  logic [SecW-1:0]    on_second;
  logic [SecW-1:0]    off_second;
  logic [LoopW-1:0]   loop_on_len;
  logic [LoopW-1:0]   loop_off_len;

  modport source (
    output valid, opcode, day_of_week, second_of_day, weekday_set,
           on_second, off_second, loop_on_len, loop_off_len,
    input  ready
  );

  modport sink (
    input  valid, opcode, day_of_week, second_of_day, weekday_set,
           on_second, off_second, loop_on_len, loop_off_len,
    output ready
  );
endinterface

interface rwsc_out_if;
  import rwsc_pkg::*;

  logic             valid;
  logic             ready;
  logic             relay_on;
  logic             loop_running;
  logic [UsedW-1:0] plans_used;
  logic [ErrW-1:0]  error_code;

  modport source (
    output valid, relay_on, loop_running, plans_used, error_code,
    input  ready
  );

  modport sink (
    input  valid, relay_on, loop_running, plans_used, error_code,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/relay_weekly_schedule_controller.sv =====
// A command transfer shows its result on the registered output in the cycle after
// it; a tick with stored plans first walks them in ST_SCAN and then shows it.
// One command per cycle while the output is not stalled; a tick holds the input
// for the walk over the stored plans, in order, through the single read port.
// Reset clears the relay, the loop and the plan count asynchronously; the plan
// memory itself is not cleared, since only written slots are ever used.
`default_nettype none

module relay_weekly_schedule_controller #(
  parameter int unsigned PLAN_SLOTS = rwsc_pkg::PlanSlotsDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  rwsc_in_if.sink     in_ch_i,
  rwsc_out_if.source  out_ch_o
);
  import rwsc_pkg::*;

  localparam int unsigned IdxW = (PLAN_SLOTS > 1) ? $clog2(PLAN_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(PLAN_SLOTS + 1);

  rwsc_state_e      state_q, state_d;
  logic             relay_q, relay_d;
  logic             loop_act_q, loop_act_d;
  logic             phase_q, phase_d;
  logic [LoopW-1:0] rem_q, rem_d;
  logic [LoopW-1:0] lon_q, lon_d;
  logic [LoopW-1:0] loff_q, loff_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [DayW-1:0]  day_q, day_d;
  logic [SecW-1:0]  sec_q, sec_d;

  logic             out_valid_q, out_valid_d;
  logic             out_relay_q, out_relay_d;
  logic             out_loop_q, out_loop_d;
  logic [UsedW-1:0] out_used_q, out_used_d;
  logic [ErrW-1:0]  out_err_q, out_err_d;

  plan_entry_t      plan_mem [PLAN_SLOTS];
  plan_entry_t      plan_rd_q;
  plan_entry_t      wr_data;
  logic             mem_we;
  logic [IdxW-1:0]  wr_addr;
  logic [IdxW-1:0]  rd_addr;

  logic             in_fire;
  logic             is_tick;
  logic             start_scan;
  logic [CntW-1:0]  idx_next;
  logic             scan_more;
  logic             today_set;
  logic             yday_set;
  logic [DayW-1:0]  yday;
  logic             now_in;

  assign in_ch_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_ch_o.ready);
  assign in_fire       = in_ch_i.valid && in_ch_i.ready;
  assign is_tick       = (in_ch_i.opcode == OP_TICK);
  assign start_scan    = in_fire && is_tick && (used_q != '0);
  assign idx_next      = CntW'(idx_q) + CntW'(1);
  assign scan_more     = (idx_next < used_q);

  assign yday      = (day_q == DAY_SUNDAY) ? DAY_SATURDAY : day_q - DayW'(1);
  assign today_set = (day_q <= DAY_SATURDAY) && plan_rd_q.days[day_q];
  assign yday_set  = (day_q <= DAY_SATURDAY) && plan_rd_q.days[yday];

  always_comb begin
    if (plan_rd_q.off_sec > plan_rd_q.on_sec) begin
      now_in = today_set && (sec_q >= plan_rd_q.on_sec) && (sec_q < plan_rd_q.off_sec);
    end else begin
      now_in = (today_set && (sec_q >= plan_rd_q.on_sec)) ||
               (yday_set && (sec_q < plan_rd_q.off_sec));
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_scan) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_more) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    relay_d     = relay_q;
    loop_act_d  = loop_act_q;
    phase_d     = phase_q;
    rem_d       = rem_q;
    lon_d       = lon_q;
    loff_d      = loff_q;
    used_d      = used_q;
    idx_d       = idx_q;
    day_d       = day_q;
    sec_d       = sec_q;
    out_valid_d = out_valid_q && !out_ch_o.ready;
    out_relay_d = out_relay_q;
    out_loop_d  = out_loop_q;
    out_used_d  = out_used_q;
    out_err_d   = out_err_q;
    mem_we      = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    rd_addr     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          out_err_d = ERR_NONE;
          if (in_ch_i.opcode inside {[OP_OFF:OP_PLAN]}) begin
            loop_act_d = 1'b0;
          end
          case (in_ch_i.opcode)
            OP_TICK: begin
              if (loop_act_q) begin
                if (rem_q > LoopW'(1)) begin
                  rem_d = rem_q - LoopW'(1);
                end else begin
                  phase_d = !phase_q;
                  relay_d = !phase_q;
                  rem_d   = phase_q ? loff_q : lon_q;
                end
              end
              day_d = in_ch_i.day_of_week;
              sec_d = in_ch_i.second_of_day;
              idx_d = '0;
            end
            OP_BUTTON: begin
              if (!loop_act_q) begin
                relay_d = !relay_q;
              end
            end
            OP_OFF:    relay_d = 1'b0;
            OP_ON:     relay_d = 1'b1;
            OP_TOGGLE: relay_d = !relay_q;
            OP_LOOP: begin
              if ((in_ch_i.loop_on_len == '0) || (in_ch_i.loop_off_len == '0)) begin
                out_err_d = ERR_LOOP;
              end else begin
                lon_d      = in_ch_i.loop_on_len;
                loff_d     = in_ch_i.loop_off_len;
                loop_act_d = 1'b1;
                phase_d    = 1'b1;
                rem_d      = in_ch_i.loop_on_len;
                relay_d    = 1'b1;
              end
            end
            OP_PLAN: begin
              if (used_q < CntW'(PLAN_SLOTS)) begin
                mem_we            = 1'b1;
                wr_addr           = used_q[IdxW-1:0];
                wr_data.days      = in_ch_i.weekday_set;
                wr_data.on_sec    = in_ch_i.on_second;
                wr_data.off_sec   = in_ch_i.off_second;
                wr_data.in_window = 1'b0;
                used_d            = used_q + CntW'(1);
              end else begin
                out_err_d = ERR_FULL;
              end
            end
            default: ;
          endcase
          if (!start_scan) begin
            out_valid_d = 1'b1;
            out_relay_d = relay_d;
            out_loop_d  = loop_act_d;
            out_used_d  = UsedW'(used_d);
          end
        end
      end
      ST_SCAN: begin
        if (now_in && !plan_rd_q.in_window) begin
          relay_d = 1'b1;
        end else if (!now_in && plan_rd_q.in_window) begin
          relay_d = 1'b0;
        end
        mem_we            = 1'b1;
        wr_addr           = idx_q;
        wr_data           = plan_rd_q;
        wr_data.in_window = now_in;
        if (scan_more) begin
          idx_d   = idx_next[IdxW-1:0];
          rd_addr = idx_next[IdxW-1:0];
        end else begin
          out_valid_d = 1'b1;
          out_relay_d = relay_d;
          out_loop_d  = loop_act_q;
          out_used_d  = UsedW'(used_q);
          out_err_d   = ERR_NONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      plan_mem[wr_addr] <= wr_data;
    end
    plan_rd_q <= plan_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      relay_q     <= 1'b0;
      loop_act_q  <= 1'b0;
      phase_q     <= 1'b0;
      rem_q       <= '0;
      lon_q       <= '0;
      loff_q      <= '0;
      used_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      relay_q     <= relay_d;
      loop_act_q  <= loop_act_d;
      phase_q     <= phase_d;
      rem_q       <= rem_d;
      lon_q       <= lon_d;
      loff_q      <= loff_d;
      used_q      <= used_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q       <= day_d;
    sec_q       <= sec_d;
    out_relay_q <= out_relay_d;
    out_loop_q  <= out_loop_d;
    out_used_q  <= out_used_d;
    out_err_q   <= out_err_d;
  end

  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.relay_on     = out_relay_q;
  assign out_ch_o.loop_running = out_loop_q;
  assign out_ch_o.plans_used   = out_used_q;
  assign out_ch_o.error_code   = out_err_q;

  // The walk must stay on written slots and write back only the slot it read.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(PLAN_SLOTS))
    else $error("plan count beyond table size");

  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CntW'(idx_q) < used_q))
    else $error("scan index past stored plans");

  a_scan_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (mem_we && (wr_addr == idx_q) && !in_ch_i.ready))
    else $error("scan write-back misplaced or input open during scan");

  a_loop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loop_act_q |-> (rem_q != '0))
    else $error("running loop with empty counter");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_scan |=> ((state_q == ST_SCAN) && !out_valid_q))
    else $error("tick walk did not start cleanly");

endmodule

`default_nettype wire

// ===== verif/relay_weekly_schedule_controller_test.sv =====
`timescale 1ns / 1ps

module relay_weekly_schedule_controller_test;
  import rwsc_pkg::*;

  localparam int unsigned PlanSlots     = PlanSlotsDefault;
  localparam int unsigned SecondsPerDay = 86400;
  localparam int unsigned SecMax        = 131071;
  localparam int unsigned RandomItems   = 550;
  localparam int unsigned QuietFirst    = 200;
  localparam int unsigned QuietLast     = 320;
  localparam int unsigned DrainCycles   = PlanSlots + 10;
  localparam int unsigned CycleLimit    = 300000;

  localparam logic [OpcodeW-1:0] OP_UNUSED = 3'd7;
  localparam logic [DayW-1:0]    DAY_NONE  = 3'd7;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [DayW-1:0]    day_of_week;
    logic [SecW-1:0]    second_of_day;
    logic [DaysW-1:0]   weekday_set;
    logic [SecW-1:0]    on_second;
    logic [SecW-1:0]    off_second;
    logic [LoopW-1:0]   loop_on_len;
    logic [LoopW-1:0]   loop_off_len;
  } relay_cmd_t;

  typedef struct packed {
    logic             relay_on;
    logic             loop_running;
    logic [UsedW-1:0] plans_used;
    logic [ErrW-1:0]  error_code;
  } relay_status_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rwsc_in_if  in_ch ();
  rwsc_out_if out_ch ();

  relay_weekly_schedule_controller dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch.sink),
    .out_ch_o (out_ch.source)
  );

  always #1 clk_i = ~clk_i;

  relay_cmd_t    pending_cmds[$];
  relay_status_t expected_status[$];
  int unsigned   boundary_secs[$];

  relay_cmd_t    next_cmd;
  relay_cmd_t    seen_cmd;
  relay_status_t want_status;
  relay_status_t got_status;

  int unsigned sent_cnt     = 0;
  int unsigned result_cnt   = 0;
  int unsigned fail_cnt     = 0;
  int unsigned cycle_cnt    = 0;
  logic        in_taken     = 1'b0;

  int unsigned clock_day = 0;
  int unsigned clock_sec = 0;

  // Scheduler state as seen from outside.
  bit               relay_lvl      = 1'b0;
  bit               loop_run       = 1'b0;
  bit               loop_phase     = 1'b0;
  int unsigned      loop_left      = 0;
  int unsigned      loop_on_ticks  = 0;
  int unsigned      loop_off_ticks = 0;
  int unsigned      slots_taken    = 0;
  logic [DaysW-1:0] slot_days   [PlanSlots];
  logic [SecW-1:0]  slot_on     [PlanSlots];
  logic [SecW-1:0]  slot_off    [PlanSlots];
  bit               slot_inside [PlanSlots] = '{default: 1'b0};

  function automatic bit plan_covers(int unsigned slot, logic [DayW-1:0] day,
                                     logic [SecW-1:0] sec);
    int unsigned d;
    bit          today;
    bit          yesterday;
    d         = day;
    today     = (d <= 6) && slot_days[slot][d];
    yesterday = (d <= 6) && slot_days[slot][(d + 6) % 7];
    if (slot_off[slot] > slot_on[slot]) begin
      return today && sec >= slot_on[slot] && sec < slot_off[slot];
    end
    return (today && sec >= slot_on[slot]) || (yesterday && sec < slot_off[slot]);
  endfunction

  function automatic relay_status_t predict_status(relay_cmd_t c);
    relay_status_t   s;
    logic [ErrW-1:0] err;
    bit              now_in;
    err = ERR_NONE;
    if (c.opcode >= OP_OFF && c.opcode <= OP_PLAN) begin
      loop_run = 1'b0;
    end
    case (c.opcode)
      OP_TICK: begin
        if (loop_run) begin
          if (loop_left > 1) begin
            loop_left--;
          end else begin
            loop_phase = !loop_phase;
            relay_lvl  = loop_phase;
            loop_left  = loop_phase ? loop_on_ticks : loop_off_ticks;
          end
        end
        for (int unsigned i = 0; i < slots_taken; i++) begin
          now_in = plan_covers(i, c.day_of_week, c.second_of_day);
          if (now_in && !slot_inside[i]) begin
            relay_lvl = 1'b1;
          end else if (!now_in && slot_inside[i]) begin
            relay_lvl = 1'b0;
          end
          slot_inside[i] = now_in;
        end
      end
      OP_BUTTON: begin
        if (!loop_run) begin
          relay_lvl = !relay_lvl;
        end
      end
      OP_OFF:    relay_lvl = 1'b0;
      OP_ON:     relay_lvl = 1'b1;
      OP_TOGGLE: relay_lvl = !relay_lvl;
      OP_LOOP: begin
        if (c.loop_on_len == 0 || c.loop_off_len == 0) begin
          err = ERR_LOOP;
        end else begin
          loop_on_ticks  = c.loop_on_len;
          loop_off_ticks = c.loop_off_len;
          loop_run       = 1'b1;
          loop_phase     = 1'b1;
          loop_left      = c.loop_on_len;
          relay_lvl      = 1'b1;
        end
      end
      OP_PLAN: begin
        if (slots_taken < PlanSlots) begin
          slot_days[slots_taken]   = c.weekday_set;
          slot_on[slots_taken]     = c.on_second;
          slot_off[slots_taken]    = c.off_second;
          slot_inside[slots_taken] = 1'b0;
          slots_taken++;
        end else begin
          err = ERR_FULL;
        end
      end
      default: ;
    endcase
    s.relay_on     = relay_lvl;
    s.loop_running = loop_run;
    s.plans_used   = UsedW'(slots_taken);
    s.error_code   = err;
    return s;
  endfunction

  // Fields that the opcode does not use still carry random values.
  function automatic relay_cmd_t random_cmd(logic [OpcodeW-1:0] op);
    relay_cmd_t c;
    c.opcode        = op;
    c.day_of_week   = DayW'($urandom_range(7));
    c.second_of_day = SecW'($urandom_range(SecMax));
    c.weekday_set   = DaysW'($urandom_range(127));
    c.on_second     = SecW'($urandom_range(SecMax));
    c.off_second    = SecW'($urandom_range(SecMax));
    c.loop_on_len   = LoopW'($urandom);
    c.loop_off_len  = LoopW'($urandom);
    return c;
  endfunction

  task automatic add_cmd(logic [OpcodeW-1:0] op);
    pending_cmds.push_back(random_cmd(op));
  endtask

  task automatic add_tick(int unsigned day, int unsigned sec);
    relay_cmd_t c;
    c               = random_cmd(OP_TICK);
    c.day_of_week   = DayW'(day);
    c.second_of_day = SecW'(sec);
    pending_cmds.push_back(c);
  endtask

  task automatic add_loop(int unsigned on_len, int unsigned off_len);
    relay_cmd_t c;
    c              = random_cmd(OP_LOOP);
    c.loop_on_len  = LoopW'(on_len);
    c.loop_off_len = LoopW'(off_len);
    pending_cmds.push_back(c);
  endtask

  task automatic add_plan(int unsigned days, int unsigned on_sec, int unsigned off_sec);
    relay_cmd_t c;
    c             = random_cmd(OP_PLAN);
    c.weekday_set = DaysW'(days);
    c.on_second   = SecW'(on_sec);
    c.off_second  = SecW'(off_sec);
    boundary_secs.push_back(on_sec);
    boundary_secs.push_back(off_sec);
    pending_cmds.push_back(c);
  endtask

  // Mostly a running wall clock, often landing next to a plan edge.
  task automatic add_clock_tick();
    int unsigned pick;
    int unsigned spot;
    pick = $urandom_range(99);
    if (pick < 55) begin
      clock_sec += $urandom_range(1, 3);
      if (clock_sec >= SecondsPerDay) begin
        clock_sec = (clock_sec - SecondsPerDay) % SecondsPerDay;
        clock_day = (clock_day + 1) % 7;
      end
    end else if (pick < 85 && boundary_secs.size() > 0) begin
      spot      = boundary_secs[$urandom_range(boundary_secs.size() - 1)];
      clock_sec = (spot > 0) ? spot - $urandom_range(1) : spot;
      clock_day = $urandom_range(6);
    end else begin
      clock_day = $urandom_range(7);
      clock_sec = $urandom_range(SecMax);
    end
    add_tick(clock_day, clock_sec);
  endtask

  task automatic add_random_loop();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      add_loop(0, $urandom_range(1, 3));
    end else if (pick < 10) begin
      add_loop($urandom_range(1, 3), 0);
    end else if (pick < 15) begin
      add_loop($urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF));
    end else begin
      add_loop($urandom_range(1, 3), $urandom_range(1, 3));
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!in_ch.valid || in_taken)) begin
      if (pending_cmds.size() > 0 &&
          ((sent_cnt >= QuietFirst && sent_cnt <= QuietLast) ||
           $urandom_range(99) >= 35)) begin
        next_cmd = pending_cmds.pop_front();
        sent_cnt++;
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= next_cmd.opcode;
        in_ch.day_of_week   <= next_cmd.day_of_week;
        in_ch.second_of_day <= next_cmd.second_of_day;
        in_ch.weekday_set   <= next_cmd.weekday_set;
        in_ch.on_second     <= next_cmd.on_second;
        in_ch.off_second    <= next_cmd.off_second;
        in_ch.loop_on_len   <= next_cmd.loop_on_len;
        in_ch.loop_off_len  <= next_cmd.loop_off_len;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= (result_cnt >= QuietFirst && result_cnt <= QuietLast) ||
                    ($urandom_range(99) >= 35);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        seen_cmd.opcode        = in_ch.opcode;
        seen_cmd.day_of_week   = in_ch.day_of_week;
        seen_cmd.second_of_day = in_ch.second_of_day;
        seen_cmd.weekday_set   = in_ch.weekday_set;
        seen_cmd.on_second     = in_ch.on_second;
        seen_cmd.off_second    = in_ch.off_second;
        seen_cmd.loop_on_len   = in_ch.loop_on_len;
        seen_cmd.loop_off_len  = in_ch.loop_off_len;
        expected_status.push_back(predict_status(seen_cmd));
      end
      if (out_ch.valid && out_ch.ready) begin
        result_cnt++;
        got_status.relay_on     = out_ch.relay_on;
        got_status.loop_running = out_ch.loop_running;
        got_status.plans_used   = out_ch.plans_used;
        got_status.error_code   = out_ch.error_code;
        if (expected_status.size() == 0) begin
          fail_cnt++;
          $display("%0t: status transfer with none expected, actual relay=%0b loop=%0b plans=%0d err=%0d",
                   $time, got_status.relay_on, got_status.loop_running,
                   got_status.plans_used, got_status.error_code);
        end else begin
          want_status = expected_status.pop_front();
          if (got_status.relay_on !== want_status.relay_on ||
              got_status.loop_running !== want_status.loop_running ||
              got_status.plans_used !== want_status.plans_used ||
              got_status.error_code !== want_status.error_code) begin
            fail_cnt++;
            $display("%0t: status mismatch, expected relay=%0b loop=%0b plans=%0d err=%0d, actual relay=%0b loop=%0b plans=%0d err=%0d",
                     $time, want_status.relay_on, want_status.loop_running,
                     want_status.plans_used, want_status.error_code,
                     got_status.relay_on, got_status.loop_running,
                     got_status.plans_used, got_status.error_code);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("relay_weekly_schedule_controller regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned total;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = OP_TICK;
    in_ch.day_of_week   = DAY_SUNDAY;
    in_ch.second_of_day = '0;
    in_ch.weekday_set   = '0;
    in_ch.on_second     = '0;
    in_ch.off_second    = '0;
    in_ch.loop_on_len   = '0;
    in_ch.loop_off_len  = '0;
    out_ch.ready        = 1'b0;

    add_tick(DAY_SUNDAY, 0);
    add_cmd(OP_BUTTON);
    add_cmd(OP_ON);
    add_cmd(OP_OFF);
    add_cmd(OP_TOGGLE);
    add_loop(0, 5);
    add_loop(5, 0);
    add_loop(1, 2);
    add_tick(DAY_SUNDAY, 1);
    add_cmd(OP_BUTTON);
    add_cmd(OP_UNUSED);
    add_tick(DAY_SUNDAY, 2);
    add_loop(24'hFFFFFF, 24'hFFFFFF);
    add_cmd(OP_TOGGLE);
    add_plan(7'h7F, 0, SecondsPerDay - 1);
    add_plan(7'h00, 100, 200);
    add_plan(7'h01, SecondsPerDay - 1, 0);
    add_plan(7'h40, 80000, 3600);
    add_plan(7'h2A, 5000, 5000);
    add_plan(7'h55, 65536, SecMax);
    repeat (PlanSlots - 6) begin
      add_plan($urandom_range(127), $urandom_range(SecondsPerDay - 1),
               $urandom_range(SecondsPerDay - 1));
    end
    add_plan(7'h7F, 10, 20);
    add_tick(DAY_NONE, SecMax);
    add_tick(DAY_SATURDAY, SecondsPerDay - 1);

    total = pending_cmds.size() + RandomItems;
    while (pending_cmds.size() < total) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        add_random_loop();
        repeat ($urandom_range(2, 8)) begin
          pick = $urandom_range(9);
          if (pick == 0) begin
            add_cmd(OP_BUTTON);
          end else if (pick == 1) begin
            add_cmd(OP_UNUSED);
          end else begin
            add_clock_tick();
          end
        end
      end else if (pick < 65) begin
        repeat ($urandom_range(3, 8)) add_clock_tick();
      end else begin
        case ($urandom_range(1, 7))
          1: add_cmd(OP_BUTTON);
          2: add_cmd(OP_OFF);
          3: add_cmd(OP_ON);
          4: add_cmd(OP_TOGGLE);
          5: add_random_loop();
          6: add_plan($urandom_range(127), $urandom_range(SecMax), $urandom_range(SecMax));
          default: add_cmd(OP_UNUSED);
        endcase
      end
    end

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || in_ch.valid || expected_status.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("relay_weekly_schedule_controller regression: pass");
    end else begin
      $display("relay_weekly_schedule_controller regression: fail");
    end
    $finish;
  end

endmodule
